// ===== rtl/tcc_pkg.sv =====
// Shared types, widths, codes and constant tables for the tilt-compensated compass.
// No dependencies; every other file depends on this package.
package tcc_pkg;

    // Field widths
    localparam int IN_W  = 16;
    localparam int OFF_W = 17;
    localparam int CAL_W = 20;
    localparam int ANG_W = 16;
    localparam int G_W   = 16;

    // Fixed-point setup
    localparam int CORDIC_STEPS = 16;
    localparam int FRAC_BITS    = 12;
    localparam int START_EXTENT = 200;
    localparam int TAB_LEN      = 24;
    localparam int TAB_IW       = $clog2(TAB_LEN);
    localparam int STEP_N       = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;

    // Divider widths: |2m - off| fits IN_W bits
    localparam int C2_W  = IN_W + 2;
    localparam int MAG_W = IN_W + FRAC_BITS - 1;
    localparam int NUM_W = MAG_W + 2;
    localparam int DEN_W = G_W + 1;
    localparam int REM_W = DEN_W + 1;

    // CORDIC and multiplier widths
    localparam int VEC_SHIFT = 20;
    localparam int CW    = 43;
    localparam int ZW    = 34;
    localparam int SC_W  = 32;
    localparam int PA_W  = 22;
    localparam int PR_W  = PA_W + SC_W;
    localparam int ACC_W = PR_W - 30;
    localparam int DW    = ZW + 7;

    localparam int N_POPS  = 12;
    localparam int IDX_MAX = (NUM_W > STEP_N) ? ((NUM_W > N_POPS) ? NUM_W : N_POPS)
                                              : ((STEP_N > N_POPS) ? STEP_N : N_POPS);
    localparam int IDX_W   = $clog2(IDX_MAX);

    localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(64'sd1073741824);
    localparam logic signed [ZW-1:0] Z_HALF    = ZW'(64'sd2147483648);
    localparam logic signed [CW-1:0] INV_GAIN  = CW'(64'sh26DD3B6A);
    localparam logic signed [CAL_W-1:0] SAT_HI = CAL_W'(524287);
    localparam logic signed [CAL_W-1:0] SAT_LO = CAL_W'(-524288);
    localparam logic signed [ANG_W-1:0] ANG_MAX = ANG_W'(23040);
    localparam logic [G_W-1:0] GAIN_RESET = G_W'(1090);

    // Selector codes: axis for the divider, angle for the CORDIC passes
    localparam logic [1:0] SEL_X     = 2'd0;
    localparam logic [1:0] SEL_Y     = 2'd1;
    localparam logic [1:0] SEL_Z     = 2'd2;
    localparam logic [1:0] SEL_ROLL  = 2'd0;
    localparam logic [1:0] SEL_PITCH = 2'd1;
    localparam logic [1:0] SEL_HEAD  = 2'd2;

    typedef enum logic [3:0] {
        DOP_NOP, DOP_TRACK, DOP_DLOAD, DOP_DSTEP, DOP_DSTORE, DOP_VLOAD, DOP_RLOAD,
        DOP_CSTEP, DOP_VSTORE, DOP_RSTORE, DOP_MUL, DOP_ACC, DOP_OUT
    } t_dop;

    typedef struct packed {
        t_dop             op;
        logic [1:0]       sel;
        logic [IDX_W-1:0] idx;
        logic             in_ready;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic out_free;
    } t_sts;

    // Tilt product program
    typedef enum logic [1:0] {AS_CX, AS_CY, AS_CZ, AS_TMP} t_asel;
    typedef enum logic [1:0] {BS_SR, BS_CR, BS_SP, BS_CP} t_bsel;
    typedef enum logic [1:0] {PD_TMP, PD_SET, PD_ADD, PD_SUB} t_pdst;
    typedef enum logic [1:0] {PS_NONE, PS_HX, PS_HY, PS_VZ} t_pst;

    typedef struct packed {
        t_asel a;
        t_bsel b;
        t_pdst d;
        t_pst  st;
    } t_pop;

    function automatic t_pop pop(input logic [IDX_W-1:0] k);
        t_pop p;
        case (k)
            IDX_W'(0):  p = '{AS_CX,  BS_CR, PD_SET, PS_NONE};
            IDX_W'(1):  p = '{AS_CY,  BS_SP, PD_TMP, PS_NONE};
            IDX_W'(2):  p = '{AS_TMP, BS_SR, PD_ADD, PS_NONE};
            IDX_W'(3):  p = '{AS_CZ,  BS_CP, PD_TMP, PS_NONE};
            IDX_W'(4):  p = '{AS_TMP, BS_SR, PD_SUB, PS_HX};
            IDX_W'(5):  p = '{AS_CY,  BS_CP, PD_SET, PS_NONE};
            IDX_W'(6):  p = '{AS_CZ,  BS_SP, PD_SUB, PS_HY};
            IDX_W'(7):  p = '{AS_CX,  BS_SP, PD_SET, PS_NONE};
            IDX_W'(8):  p = '{AS_CY,  BS_SR, PD_TMP, PS_NONE};
            IDX_W'(9):  p = '{AS_TMP, BS_CP, PD_SUB, PS_NONE};
            IDX_W'(10): p = '{AS_CZ,  BS_CR, PD_TMP, PS_NONE};
            IDX_W'(11): p = '{AS_TMP, BS_CP, PD_ADD, PS_VZ};
            default:    p = '{AS_CX,  BS_CR, PD_TMP, PS_NONE};
        endcase
        return p;
    endfunction

    // Arctangent of 2^-i in 2^-32 turns
    function automatic logic [31:0] atan_tab(input logic [TAB_IW-1:0] i);
        logic [31:0] t;
        case (i)
            TAB_IW'(0):  t = 32'h20000000;
            TAB_IW'(1):  t = 32'h12E4051E;
            TAB_IW'(2):  t = 32'h09FB385B;
            TAB_IW'(3):  t = 32'h051111D4;
            TAB_IW'(4):  t = 32'h028B0D43;
            TAB_IW'(5):  t = 32'h0145D7E1;
            TAB_IW'(6):  t = 32'h00A2F61E;
            TAB_IW'(7):  t = 32'h00517C55;
            TAB_IW'(8):  t = 32'h0028BE53;
            TAB_IW'(9):  t = 32'h00145F2F;
            TAB_IW'(10): t = 32'h000A2F98;
            TAB_IW'(11): t = 32'h000517CC;
            TAB_IW'(12): t = 32'h00028BE6;
            TAB_IW'(13): t = 32'h000145F3;
            TAB_IW'(14): t = 32'h0000A2FA;
            TAB_IW'(15): t = 32'h0000517D;
            TAB_IW'(16): t = 32'h000028BE;
            TAB_IW'(17): t = 32'h0000145F;
            TAB_IW'(18): t = 32'h00000A30;
            TAB_IW'(19): t = 32'h00000518;
            TAB_IW'(20): t = 32'h0000028C;
            TAB_IW'(21): t = 32'h00000146;
            TAB_IW'(22): t = 32'h000000A3;
            TAB_IW'(23): t = 32'h00000051;
            default:     t = 32'h0;
        endcase
        return t;
    endfunction

endpackage

// ===== rtl/tcc_ifs.sv =====
// Handshake channels of the compass: sample input, result output, gain write.
// Depends on tcc_pkg for field widths.
interface tcc_in_if;
    logic valid;
    logic ready;
    logic signed [tcc_pkg::IN_W-1:0] acc_x;
    logic signed [tcc_pkg::IN_W-1:0] acc_y;
    logic signed [tcc_pkg::IN_W-1:0] acc_z;
    logic signed [tcc_pkg::IN_W-1:0] mag_x;
    logic signed [tcc_pkg::IN_W-1:0] mag_y;
    logic signed [tcc_pkg::IN_W-1:0] mag_z;
    modport source (output valid, acc_x, acc_y, acc_z, mag_x, mag_y, mag_z, input ready);
    modport sink (input valid, acc_x, acc_y, acc_z, mag_x, mag_y, mag_z, output ready);
endinterface

interface tcc_out_if;
    logic valid;
    logic ready;
    logic signed [tcc_pkg::OFF_W-1:0] offset_x;
    logic signed [tcc_pkg::OFF_W-1:0] offset_y;
    logic signed [tcc_pkg::OFF_W-1:0] offset_z;
    logic signed [tcc_pkg::CAL_W-1:0] cal_x;
    logic signed [tcc_pkg::CAL_W-1:0] cal_y;
    logic signed [tcc_pkg::CAL_W-1:0] cal_z;
    logic signed [tcc_pkg::CAL_W-1:0] horiz_x;
    logic signed [tcc_pkg::CAL_W-1:0] horiz_y;
    logic signed [tcc_pkg::CAL_W-1:0] vert_z;
    logic signed [tcc_pkg::ANG_W-1:0] roll_angle;
    logic signed [tcc_pkg::ANG_W-1:0] pitch_angle;
    logic signed [tcc_pkg::ANG_W-1:0] heading;
    modport source (output valid, offset_x, offset_y, offset_z, cal_x, cal_y, cal_z,
                    horiz_x, horiz_y, vert_z, roll_angle, pitch_angle, heading,
                    input ready);
    modport sink (input valid, offset_x, offset_y, offset_z, cal_x, cal_y, cal_z,
                  horiz_x, horiz_y, vert_z, roll_angle, pitch_angle, heading,
                  output ready);
endinterface

interface tcc_cfg_if;
    logic valid;
    logic ready;
    logic [tcc_pkg::G_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== rtl/tcc_ctrl.sv =====
// Sequencer of the compass: steps the datapath through track, divide, CORDIC and
// tilt product phases. Depends on tcc_pkg.
module tcc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tcc_pkg::t_sts i_sts,
    output tcc_pkg::t_cmd o_cmd
);
    import tcc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_TRACK, S_DLOAD, S_DSTEP, S_DSTORE, S_VLOAD, S_VSTEP, S_VSTORE,
        S_RLOAD, S_RSTEP, S_RSTORE, S_MUL, S_ACC, S_FIN
    } t_state;

    localparam logic [IDX_W-1:0] DIV_LAST  = IDX_W'(NUM_W - 1);
    localparam logic [IDX_W-1:0] CORD_LAST = IDX_W'(STEP_N - 1);
    localparam logic [IDX_W-1:0] POP_LAST  = IDX_W'(N_POPS - 1);

    t_state           r_state;
    logic [1:0]       r_sel;
    logic [IDX_W-1:0] r_idx;

    // Advance state, selector and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= 2'd0;
            r_idx   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_sts.in_valid) r_state <= S_TRACK;
                end
                S_TRACK: begin
                    r_state <= S_DLOAD;
                    r_sel   <= SEL_X;
                end
                S_DLOAD: begin
                    r_state <= S_DSTEP;
                    r_idx   <= '0;
                end
                S_DSTEP: begin
                    if (r_idx == DIV_LAST) r_state <= S_DSTORE;
                    else r_idx <= r_idx + 1'b1;
                end
                S_DSTORE: begin
                    if (r_sel == SEL_Z) begin
                        r_state <= S_VLOAD;
                        r_sel   <= SEL_ROLL;
                    end else begin
                        r_state <= S_DLOAD;
                        r_sel   <= r_sel + 1'b1;
                    end
                end
                S_VLOAD: begin
                    r_state <= S_VSTEP;
                    r_idx   <= '0;
                end
                S_VSTEP: begin
                    if (r_idx == CORD_LAST) r_state <= S_VSTORE;
                    else r_idx <= r_idx + 1'b1;
                end
                S_VSTORE: begin
                    if (r_sel == SEL_ROLL) begin
                        r_state <= S_VLOAD;
                        r_sel   <= SEL_PITCH;
                    end else if (r_sel == SEL_PITCH) begin
                        r_state <= S_RLOAD;
                        r_sel   <= SEL_ROLL;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_RLOAD: begin
                    r_state <= S_RSTEP;
                    r_idx   <= '0;
                end
                S_RSTEP: begin
                    if (r_idx == CORD_LAST) r_state <= S_RSTORE;
                    else r_idx <= r_idx + 1'b1;
                end
                S_RSTORE: begin
                    if (r_sel == SEL_ROLL) begin
                        r_state <= S_RLOAD;
                        r_sel   <= SEL_PITCH;
                    end else begin
                        r_state <= S_MUL;
                        r_idx   <= '0;
                    end
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_idx == POP_LAST) begin
                        r_state <= S_VLOAD;
                        r_sel   <= SEL_HEAD;
                    end else begin
                        r_state <= S_MUL;
                        r_idx   <= r_idx + 1'b1;
                    end
                end
                S_FIN: begin
                    if (i_sts.out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Decode state into a datapath command
    always_comb begin
        o_cmd.sel      = r_sel;
        o_cmd.idx      = r_idx;
        o_cmd.in_ready = (r_state == S_IDLE);
        case (r_state)
            S_TRACK:  o_cmd.op = DOP_TRACK;
            S_DLOAD:  o_cmd.op = DOP_DLOAD;
            S_DSTEP:  o_cmd.op = DOP_DSTEP;
            S_DSTORE: o_cmd.op = DOP_DSTORE;
            S_VLOAD:  o_cmd.op = DOP_VLOAD;
            S_VSTEP:  o_cmd.op = DOP_CSTEP;
            S_VSTORE: o_cmd.op = DOP_VSTORE;
            S_RLOAD:  o_cmd.op = DOP_RLOAD;
            S_RSTEP:  o_cmd.op = DOP_CSTEP;
            S_RSTORE: o_cmd.op = DOP_RSTORE;
            S_MUL:    o_cmd.op = DOP_MUL;
            S_ACC:    o_cmd.op = DOP_ACC;
            S_FIN:    o_cmd.op = i_sts.out_free ? DOP_OUT : DOP_NOP;
            default:  o_cmd.op = DOP_NOP;
        endcase
    end

endmodule

// ===== rtl/tcc_dpath.sv =====
// Compass datapath: min/max tracker, serial divider, shared CORDIC, tilt multiplier
// and output register. Depends on tcc_pkg and the channel interfaces.
module tcc_dpath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tcc_pkg::t_cmd i_cmd,
    output tcc_pkg::t_sts o_sts,
    tcc_in_if.sink        i_in,
    tcc_out_if.source     o_out,
    tcc_cfg_if.sink       i_cfg
);
    import tcc_pkg::*;

    localparam logic signed [IN_W-1:0] MIN_RESET = IN_W'(-START_EXTENT);
    localparam logic signed [IN_W-1:0] MAX_RESET = IN_W'(START_EXTENT);
    localparam logic [NUM_W-1:0] LIM_POS = NUM_W'(524287);
    localparam logic [NUM_W-1:0] LIM_NEG = NUM_W'(524288);

    // Convert a binary angle to 1/128 degree with clamping
    function automatic logic signed [ANG_W-1:0] deg128(input logic signed [ZW-1:0] z);
        logic signed [DW-1:0] zz;
        logic signed [DW-1:0] p;
        logic signed [DW-1:0] v;
        zz = DW'(z);
        p  = (zz <<< 5) + (zz <<< 3) + (zz <<< 2) + zz + (DW'(1) <<< 21);
        v  = p >>> 22;
        if (v > DW'(ANG_MAX)) return ANG_MAX;
        if (v < -DW'(ANG_MAX)) return -ANG_MAX;
        return ANG_W'(v);
    endfunction

    function automatic logic signed [CAL_W-1:0] sat20(input logic signed [ACC_W-1:0] v);
        if (v > ACC_W'(SAT_HI)) return SAT_HI;
        if (v < ACC_W'(SAT_LO)) return SAT_LO;
        return CAL_W'(v);
    endfunction

    logic [G_W-1:0] r_gain;
    logic signed [IN_W-1:0] r_ax, r_ay, r_az, r_mx, r_my, r_mz;
    logic signed [IN_W-1:0] r_minx, r_miny, r_minz, r_maxx, r_maxy, r_maxz;
    logic signed [CAL_W-1:0] r_cx, r_cy, r_cz, r_hx, r_hy, r_vz;
    logic [NUM_W-1:0] r_num;
    logic [REM_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic r_dneg;
    logic signed [CW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z, r_roll, r_pitch, r_head;
    logic r_vec, r_vzero, r_neg;
    logic signed [SC_W-1:0] r_sr, r_cr, r_sp, r_cp;
    logic signed [PR_W-1:0] r_prod;
    logic signed [PA_W-1:0] r_tmp;
    logic signed [ACC_W-1:0] r_acc;
    logic r_ovalid;

    logic signed [OFF_W-1:0] offx, offy, offz;
    logic signed [IN_W-1:0] dm;
    logic signed [OFF_W-1:0] doff;
    logic signed [C2_W-1:0] c2, c2_abs;
    logic [MAG_W-1:0] mag;
    logic [G_W-1:0] gain_eff;
    logic [REM_W-1:0] rem_sh;
    logic rem_ge;
    logic signed [CAL_W-1:0] n_cal;
    logic signed [CAL_W-1:0] vy, vx;
    logic signed [CW-1:0] sy, sx;
    logic signed [ZW-1:0] rz;
    logic signed [CW-1:0] dx, dy;
    logic signed [ZW-1:0] tab;
    logic ccw;
    t_pop pp;
    logic signed [PA_W-1:0] pa;
    logic signed [SC_W-1:0] pb;
    logic signed [PR_W-1:0] rnd_full;
    logic signed [ACC_W-1:0] rnd, n_acc;

    assign i_cfg.ready   = 1'b1;
    assign i_in.ready    = i_cmd.in_ready;
    assign o_out.valid   = r_ovalid;
    assign o_sts.in_valid = i_in.valid;
    assign o_sts.out_free = !r_ovalid || o_out.ready;

    assign offx = OFF_W'(r_minx) + OFF_W'(r_maxx);
    assign offy = OFF_W'(r_miny) + OFF_W'(r_maxy);
    assign offz = OFF_W'(r_minz) + OFF_W'(r_maxz);

    // Divider operands: centred field magnitude and gain
    always_comb begin
        case (i_cmd.sel)
            SEL_X:   begin dm = r_mx; doff = offx; end
            SEL_Y:   begin dm = r_my; doff = offy; end
            default: begin dm = r_mz; doff = offz; end
        endcase
        c2       = (C2_W'(dm) <<< 1) - C2_W'(doff);
        c2_abs   = c2[C2_W-1] ? -c2 : c2;
        mag      = MAG_W'(c2_abs[IN_W-1:0]) << (FRAC_BITS - 1);
        gain_eff = (r_gain == '0) ? G_W'(1) : r_gain;
        rem_sh   = {r_rem[REM_W-2:0], r_num[NUM_W-1]};
        rem_ge   = rem_sh >= REM_W'(r_den);
        if (r_dneg) n_cal = (r_num > LIM_NEG) ? SAT_LO : CAL_W'(-r_num);
        else        n_cal = (r_num > LIM_POS) ? SAT_HI : CAL_W'(r_num);
    end

    // CORDIC operand loads and one micro-rotation
    always_comb begin
        case (i_cmd.sel)
            SEL_ROLL:  begin vy = CAL_W'(r_ax); vx = CAL_W'(r_az); end
            SEL_PITCH: begin vy = CAL_W'(r_ay); vx = CAL_W'(r_az); end
            default:   begin vy = r_hy; vx = r_hx; end
        endcase
        sy  = CW'(vy) <<< VEC_SHIFT;
        sx  = CW'(vx) <<< VEC_SHIFT;
        rz  = (i_cmd.sel == SEL_ROLL) ? r_roll : r_pitch;
        dx  = r_y >>> i_cmd.idx;
        dy  = r_x >>> i_cmd.idx;
        tab = signed'(ZW'(atan_tab(TAB_IW'(i_cmd.idx))));
        ccw = r_vec ? r_y[CW-1] : !r_z[ZW-1];
    end

    // Tilt product operands and rounding
    always_comb begin
        pp = pop(i_cmd.idx);
        case (pp.a)
            AS_CX:   pa = PA_W'(r_cx);
            AS_CY:   pa = PA_W'(r_cy);
            AS_CZ:   pa = PA_W'(r_cz);
            default: pa = r_tmp;
        endcase
        case (pp.b)
            BS_SR:   pb = r_sr;
            BS_CR:   pb = r_cr;
            BS_SP:   pb = r_sp;
            default: pb = r_cp;
        endcase
        rnd_full = (r_prod + (PR_W'(1) <<< 29)) >>> 30;
        rnd      = ACC_W'(rnd_full);
        case (pp.d)
            PD_SET:  n_acc = rnd;
            PD_ADD:  n_acc = r_acc + rnd;
            PD_SUB:  n_acc = r_acc - rnd;
            default: n_acc = r_acc;
        endcase
    end

    // Gain register, tracker and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_RESET;
            r_minx   <= MIN_RESET;
            r_miny   <= MIN_RESET;
            r_minz   <= MIN_RESET;
            r_maxx   <= MAX_RESET;
            r_maxy   <= MAX_RESET;
            r_maxz   <= MAX_RESET;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg.valid) r_gain <= i_cfg.data;
            if (i_cmd.op == DOP_TRACK) begin
                if (r_mx < r_minx) r_minx <= r_mx;
                if (r_mx > r_maxx) r_maxx <= r_mx;
                if (r_my < r_miny) r_miny <= r_my;
                if (r_my > r_maxy) r_maxy <= r_my;
                if (r_mz < r_minz) r_minz <= r_mz;
                if (r_mz > r_maxz) r_maxz <= r_mz;
            end
            if (i_cmd.op == DOP_OUT) r_ovalid <= 1'b1;
            else if (o_out.ready) r_ovalid <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_ax <= i_in.acc_x;
            r_ay <= i_in.acc_y;
            r_az <= i_in.acc_z;
            r_mx <= i_in.mag_x;
            r_my <= i_in.mag_y;
            r_mz <= i_in.mag_z;
        end
        case (i_cmd.op)
            DOP_DLOAD: begin
                r_num  <= NUM_W'({mag, 1'b0}) + NUM_W'(gain_eff);
                r_den  <= {gain_eff, 1'b0};
                r_rem  <= '0;
                r_dneg <= c2[C2_W-1];
            end
            DOP_DSTEP: begin
                r_rem <= rem_ge ? rem_sh - REM_W'(r_den) : rem_sh;
                r_num <= {r_num[NUM_W-2:0], rem_ge};
            end
            DOP_DSTORE: begin
                case (i_cmd.sel)
                    SEL_X:   r_cx <= n_cal;
                    SEL_Y:   r_cy <= n_cal;
                    default: r_cz <= n_cal;
                endcase
            end
            DOP_VLOAD: begin
                r_vec   <= 1'b1;
                r_vzero <= (vx == '0) && (vy == '0);
                if (sx[CW-1]) begin
                    if (!sy[CW-1]) begin
                        r_x <= sy;
                        r_y <= -sx;
                        r_z <= Z_QUARTER;
                    end else begin
                        r_x <= -sy;
                        r_y <= sx;
                        r_z <= -Z_QUARTER;
                    end
                end else begin
                    r_x <= sx;
                    r_y <= sy;
                    r_z <= '0;
                end
            end
            DOP_RLOAD: begin
                r_vec <= 1'b0;
                r_x   <= INV_GAIN;
                r_y   <= '0;
                if (rz > Z_QUARTER) begin
                    r_z   <= rz - Z_HALF;
                    r_neg <= 1'b1;
                end else if (rz < -Z_QUARTER) begin
                    r_z   <= rz + Z_HALF;
                    r_neg <= 1'b1;
                end else begin
                    r_z   <= rz;
                    r_neg <= 1'b0;
                end
            end
            DOP_CSTEP: begin
                if (ccw) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - tab;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + tab;
                end
            end
            DOP_VSTORE: begin
                case (i_cmd.sel)
                    SEL_ROLL:  r_roll  <= r_vzero ? '0 : r_z;
                    SEL_PITCH: r_pitch <= r_vzero ? '0 : r_z;
                    default:   r_head  <= r_vzero ? '0 : r_z;
                endcase
            end
            DOP_RSTORE: begin
                if (i_cmd.sel == SEL_ROLL) begin
                    r_sr <= SC_W'(r_neg ? -r_y : r_y);
                    r_cr <= SC_W'(r_neg ? -r_x : r_x);
                end else begin
                    r_sp <= SC_W'(r_neg ? -r_y : r_y);
                    r_cp <= SC_W'(r_neg ? -r_x : r_x);
                end
            end
            DOP_MUL: begin
                r_prod <= pa * pb;
            end
            DOP_ACC: begin
                if (pp.d == PD_TMP) r_tmp <= PA_W'(rnd);
                else r_acc <= n_acc;
                case (pp.st)
                    PS_HX:   r_hx <= sat20(n_acc);
                    PS_HY:   r_hy <= sat20(n_acc);
                    PS_VZ:   r_vz <= sat20(n_acc);
                    default: ;
                endcase
            end
            DOP_OUT: begin
                o_out.offset_x    <= offx;
                o_out.offset_y    <= offy;
                o_out.offset_z    <= offz;
                o_out.cal_x       <= r_cx;
                o_out.cal_y       <= r_cy;
                o_out.cal_z       <= r_cz;
                o_out.horiz_x     <= r_hx;
                o_out.horiz_y     <= r_hy;
                o_out.vert_z      <= r_vz;
                o_out.roll_angle  <= deg128(r_roll);
                o_out.pitch_angle <= deg128(r_pitch);
                o_out.heading     <= deg128(r_head);
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/tilt_compensated_compass_unit.sv =====
// Top level of the tilt-compensated compass: sequencer plus datapath.
// Depends on tcc_pkg, the channel interfaces, tcc_ctrl and tcc_dpath.
//
//  channel | dir | payload                                           | moves on
//  i_in    | in  | acc_x/y/z, mag_x/y/z                              | valid & ready
//  o_out   | out | offset_x/y/z, cal_x/y/z, horiz_x/y, vert_z, angles | valid & ready
//  i_cfg   | in  | data = mag_gain                                   | valid & ready
//
// One item at a time: each item passes through the bit-serial gain divider and
// the shared iterative CORDIC unit before the next is accepted. Synchronous
// active-low reset restores the gain and the min/max extents. A result held in
// the output register does not stop the next item from being accepted; only
// loading a new result waits for it.
module tilt_compensated_compass_unit (
    input logic       i_clk,
    input logic       i_rst_n,
    tcc_in_if.sink    i_in,
    tcc_out_if.source o_out,
    tcc_cfg_if.sink   i_cfg
);
    import tcc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    tcc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    tcc_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg)
    );

endmodule
